/* design/vwd_pkg.sv */
package vwd_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int COORD_BITS   = 24;
	localparam int IDX_W        = 12;
	localparam int CNT_W        = IDX_W + 1;
	localparam int TOL_W        = 23;
	localparam int DIST_W       = TOL_W;
	localparam int SQ_W         = 2 * DIST_W;
	localparam int SUM_W        = SQ_W + 2;
	localparam int POS_W        = 3 * COORD_BITS;

	// item kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_REMAP  = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_UNSEEN = 2'd2;

	typedef struct packed {
		logic [1:0]                   kind;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
		logic signed [COORD_BITS-1:0] pos_z;
		logic [IDX_W-1:0]             vertex_index;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] welded_index;
		logic             is_new;
		logic [1:0]       status;
	} result_t;

endpackage

/* design/vertex_weld_dedup.sv */
// channel  | handshake                | payload                | dir
// item     | item_valid / item_stall  | item (vwd_pkg::item_t) | in
// result   | result_valid/result_stall| result (result_t)      | out
// cfg      | cfg_valid / cfg_ready    | cfg_data (tolerance)   | in
//
// One item at a time. For a vertex item the position memory gives one stored entry per
// cycle into a three-stage distance pipeline, and the first match or a miss on the last
// entry ends the scan. With an empty table a vertex skips the scan. An in-range index
// item does one remap memory read; an unseen index, clear and other kinds skip it.
// arst_n clears counts, tolerance and handshake state; memories are not cleared.
// A stalled result holds in its register; the block takes the next item meanwhile,
// and that item then waits to hand over until the register frees.
module vertex_weld_dedup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  vwd_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output vwd_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vwd_pkg::TOL_W-1:0]  cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LOOK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                  state_q;
	logic [vwd_pkg::TOL_W-1:0]   tol_q;
	logic [vwd_pkg::SQ_W-1:0]    tol_sq_q;
	logic [vwd_pkg::CNT_W-1:0]   uniq_cnt_q;
	logic [vwd_pkg::CNT_W-1:0]   vert_cnt_q;
	logic [vwd_pkg::CNT_W-1:0]   issue_q;

	logic signed [vwd_pkg::COORD_BITS-1:0] px_q, py_q, pz_q;

	// pending result and its write-back actions
	vwd_pkg::result_t            pend_q;
	logic                        append_q;
	logic                        record_q;

	vwd_pkg::result_t            result_q;
	logic                        result_valid_q;

	// distance pipeline
	logic                        valid_s1, valid_s2, valid_s3;
	logic [vwd_pkg::IDX_W-1:0]   idx_s1, idx_s2, idx_s3;
	logic [vwd_pkg::DIST_W-1:0]  dx_s2, dy_s2, dz_s2;
	logic                        near_s2, near_s3;
	logic [vwd_pkg::SQ_W-1:0]    sqx_s3, sqy_s3, sqz_s3;

	logic [vwd_pkg::POS_W-1:0]   pos_rdata;
	logic [vwd_pkg::IDX_W-1:0]   remap_rdata;

	logic                        accept;
	logic                        slot_free;
	logic                        push;
	logic                        issue;
	logic                        hit;
	logic                        miss_end;
	logic                        scan_exit;
	logic [vwd_pkg::CNT_W-1:0]   last_idx;
	logic [vwd_pkg::SUM_W-1:0]   dist_sum;
	logic                        uniq_full;
	logic                        vert_full;
	logic                        append_fire;

	logic signed [vwd_pkg::COORD_BITS-1:0] ux, uy, uz;
	logic signed [vwd_pkg::COORD_BITS:0]   ddx, ddy, ddz;
	logic [vwd_pkg::COORD_BITS:0]          adx, ady, adz;

	assign accept    = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !result_valid_q || !result_stall;
	assign push      = (state_q == S_DONE) && slot_free;
	assign uniq_full = (uniq_cnt_q == vwd_pkg::CNT_W'(vwd_pkg::MAX_VERTICES));
	assign vert_full = (vert_cnt_q == vwd_pkg::CNT_W'(vwd_pkg::MAX_VERTICES));
	assign append_fire = push && append_q;

	// issue one stored entry per cycle until the table end or a scan exit
	assign issue    = (state_q == S_SCAN) && (issue_q < uniq_cnt_q) && !scan_exit;
	assign last_idx = uniq_cnt_q - vwd_pkg::CNT_W'(1);

	// final compare: sum of squares strictly below tolerance squared
	assign dist_sum = vwd_pkg::SUM_W'(sqx_s3) + vwd_pkg::SUM_W'(sqy_s3)
		+ vwd_pkg::SUM_W'(sqz_s3);
	assign hit      = (state_q == S_SCAN) && valid_s3 && near_s3
		&& (dist_sum < vwd_pkg::SUM_W'(tol_sq_q));
	assign miss_end = (state_q == S_SCAN) && valid_s3 && !hit
		&& ({1'b0, idx_s3} == last_idx);
	assign scan_exit = hit || miss_end;

	// stored unique positions, x/y/z side by side
	vwd_ram #(
		.WIDTH (vwd_pkg::POS_W),
		.DEPTH (vwd_pkg::MAX_VERTICES)
	) u_pos_ram (
		.clk   (clk),
		.we    (append_fire),
		.waddr (uniq_cnt_q[vwd_pkg::IDX_W-1:0]),
		.wdata ({px_q, py_q, pz_q}),
		.raddr (issue_q[vwd_pkg::IDX_W-1:0]),
		.rdata (pos_rdata)
	);

	// unique index per vertex number
	vwd_ram #(
		.WIDTH (vwd_pkg::IDX_W),
		.DEPTH (vwd_pkg::MAX_VERTICES)
	) u_remap_ram (
		.clk   (clk),
		.we    (push && record_q),
		.waddr (vert_cnt_q[vwd_pkg::IDX_W-1:0]),
		.wdata (pend_q.welded_index),
		.raddr (item.vertex_index),
		.rdata (remap_rdata)
	);

	// absolute per-axis differences
	always_comb begin
		ux  = pos_rdata[3*vwd_pkg::COORD_BITS-1:2*vwd_pkg::COORD_BITS];
		uy  = pos_rdata[2*vwd_pkg::COORD_BITS-1:vwd_pkg::COORD_BITS];
		uz  = pos_rdata[vwd_pkg::COORD_BITS-1:0];
		ddx = (vwd_pkg::COORD_BITS+1)'(px_q) - (vwd_pkg::COORD_BITS+1)'(ux);
		ddy = (vwd_pkg::COORD_BITS+1)'(py_q) - (vwd_pkg::COORD_BITS+1)'(uy);
		ddz = (vwd_pkg::COORD_BITS+1)'(pz_q) - (vwd_pkg::COORD_BITS+1)'(uz);
		adx = ddx[vwd_pkg::COORD_BITS] ? (vwd_pkg::COORD_BITS+1)'(0) - ddx : ddx;
		ady = ddy[vwd_pkg::COORD_BITS] ? (vwd_pkg::COORD_BITS+1)'(0) - ddy : ddy;
		adz = ddz[vwd_pkg::COORD_BITS] ? (vwd_pkg::COORD_BITS+1)'(0) - ddz : ddz;
	end

	// advance the distance pipeline, drop in-flight entries on scan exit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && !scan_exit;
			valid_s3 <= valid_s2 && !scan_exit;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= issue_q[vwd_pkg::IDX_W-1:0];
		idx_s2  <= idx_s1;
		near_s2 <= (adx < (vwd_pkg::COORD_BITS+1)'(tol_q))
			&& (ady < (vwd_pkg::COORD_BITS+1)'(tol_q))
			&& (adz < (vwd_pkg::COORD_BITS+1)'(tol_q));
		dx_s2   <= adx[vwd_pkg::DIST_W-1:0];
		dy_s2   <= ady[vwd_pkg::DIST_W-1:0];
		dz_s2   <= adz[vwd_pkg::DIST_W-1:0];
		idx_s3  <= idx_s2;
		near_s3 <= near_s2;
		sqx_s3  <= dx_s2 * dx_s2;
		sqy_s3  <= dy_s2 * dy_s2;
		sqz_s3  <= dz_s2 * dz_s2;
	end

	// tolerance register and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= '0;
			tol_sq_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			tol_sq_q <= tol_q * tol_q;
		end
	end

	// hold the vertex position for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q <= item.pos_x;
			py_q <= item.pos_y;
			pz_q <= item.pos_z;
		end
	end

	// sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			uniq_cnt_q <= '0;
			vert_cnt_q <= '0;
			issue_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					issue_q <= '0;
					if (accept) begin
						unique case (item.kind)
							vwd_pkg::KIND_VERTEX: begin
								state_q <= (uniq_cnt_q == '0) ? S_DONE : S_SCAN;
							end
							vwd_pkg::KIND_REMAP: begin
								state_q <= ({1'b0, item.vertex_index} < vert_cnt_q)
									? S_LOOK : S_DONE;
							end
							vwd_pkg::KIND_CLEAR: begin
								uniq_cnt_q <= '0;
								vert_cnt_q <= '0;
								state_q    <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (issue) begin
						issue_q <= issue_q + vwd_pkg::CNT_W'(1);
					end
					if (scan_exit) begin
						state_q <= S_DONE;
					end
				end
				S_LOOK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (push) begin
						state_q <= S_IDLE;
						if (append_q) begin
							uniq_cnt_q <= uniq_cnt_q + vwd_pkg::CNT_W'(1);
						end
						if (record_q) begin
							vert_cnt_q <= vert_cnt_q + vwd_pkg::CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// build the pending result and its write-back actions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			append_q <= 1'b0;
			record_q <= 1'b0;
		end else begin
			if (accept) begin
				append_q <= (item.kind == vwd_pkg::KIND_VERTEX) && (uniq_cnt_q == '0);
				record_q <= (item.kind == vwd_pkg::KIND_VERTEX) && (uniq_cnt_q == '0)
					&& !vert_full;
			end else if (miss_end) begin
				append_q <= !uniq_full;
				record_q <= !uniq_full && !vert_full;
			end else if (hit) begin
				record_q <= !vert_full;
			end else if (push) begin
				append_q <= 1'b0;
				record_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q.welded_index <= '0;
			pend_q.is_new <= (item.kind == vwd_pkg::KIND_VERTEX) && (uniq_cnt_q == '0);
			pend_q.status <= (item.kind == vwd_pkg::KIND_REMAP
				&& !({1'b0, item.vertex_index} < vert_cnt_q))
				? vwd_pkg::ST_UNSEEN : vwd_pkg::ST_OK;
		end else if (hit) begin
			pend_q.welded_index <= idx_s3;
		end else if (miss_end) begin
			if (uniq_full) begin
				pend_q.status <= vwd_pkg::ST_FULL;
			end else begin
				pend_q.welded_index <= uniq_cnt_q[vwd_pkg::IDX_W-1:0];
				pend_q.is_new       <= 1'b1;
			end
		end else if (state_q == S_LOOK) begin
			pend_q.welded_index <= remap_rdata;
		end
	end

	// output register: load on push, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (push) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			result_q <= pend_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		uniq_cnt_q <= vwd_pkg::CNT_W'(vwd_pkg::MAX_VERTICES)
		&& vert_cnt_q <= vwd_pkg::CNT_W'(vwd_pkg::MAX_VERTICES))
		else $error("count beyond table size");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && valid_s3) |-> ({1'b0, idx_s3} < uniq_cnt_q))
		else $error("scan read past the unique table");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		append_fire |=> (uniq_cnt_q == $past(uniq_cnt_q) + vwd_pkg::CNT_W'(1)))
		else $error("append did not grow the unique count");

	a_new_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pend_q.is_new) |-> (pend_q.status == vwd_pkg::ST_OK && append_q))
		else $error("new entry reported without an append");

endmodule

/* design/vwd_ram.sv */
module vwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint     COORD_MAX   = 8388607;
	localparam longint     COORD_MIN   = -8388608;
	localparam int         TOL_MAX     = 8388607;
	localparam int         SETTLE      = 16;
	localparam int         LONG_HOLD   = 300;
	// scans stay short (small meshes), so this is many times the slowest legal run
	localparam int         CYCLE_LIMIT = 2000000;

	// Shadow of the welder: unique positions, remap store, counts and tolerance.
	class weld_tracker;
		longint                ux[vwd_pkg::MAX_VERTICES];
		longint                uy[vwd_pkg::MAX_VERTICES];
		longint                uz[vwd_pkg::MAX_VERTICES];
		int unsigned           remap_of[vwd_pkg::MAX_VERTICES];
		int unsigned           n_unique;
		int unsigned           n_vertex;
		longint                tol;
		vwd_pkg::result_t      pending_welds[$];
		int                    mismatches;
		int                    results_seen;

		function void set_tolerance(logic [vwd_pkg::TOL_W-1:0] v);
			tol = v;
		endfunction

		// strict test: squared distance below squared tolerance
		function bit is_near(longint x, longint y, longint z, int unsigned j);
			longint dx, dy, dz;
			dx = (x >= ux[j]) ? x - ux[j] : ux[j] - x;
			dy = (y >= uy[j]) ? y - uy[j] : uy[j] - y;
			dz = (z >= uz[j]) ? z - uz[j] : uz[j] - z;
			if (dx >= tol || dy >= tol || dz >= tol)
				return 1'b0;
			return dx * dx + dy * dy + dz * dz < tol * tol;
		endfunction

		// Work out the answer to one accepted request and queue it.
		function void note_request(vwd_pkg::item_t req);
			vwd_pkg::result_t r;
			longint           x, y, z;
			int unsigned      found;
			r = '0;
			unique case (req.kind)
				vwd_pkg::KIND_VERTEX: begin
					x = $signed(req.pos_x);
					y = $signed(req.pos_y);
					z = $signed(req.pos_z);
					found = n_unique;
					for (int unsigned j = 0; j < n_unique; j++) begin
						if (is_near(x, y, z, j)) begin
							found = j;
							break;
						end
					end
					// append when nothing matched, drop when the table is full
					if (found == n_unique) begin
						if (n_unique >= vwd_pkg::MAX_VERTICES) begin
							r.status = vwd_pkg::ST_FULL;
						end else begin
							ux[found] = x;
							uy[found] = y;
							uz[found] = z;
							n_unique++;
							r.is_new = 1'b1;
						end
					end
					if (r.status == vwd_pkg::ST_OK) begin
						r.welded_index = vwd_pkg::IDX_W'(found);
						// record only while vertex numbers remain
						if (n_vertex < vwd_pkg::MAX_VERTICES) begin
							remap_of[n_vertex] = found;
							n_vertex++;
						end
					end
				end
				vwd_pkg::KIND_REMAP: begin
					if (req.vertex_index < n_vertex)
						r.welded_index = vwd_pkg::IDX_W'(remap_of[req.vertex_index]);
					else
						r.status = vwd_pkg::ST_UNSEEN;
				end
				vwd_pkg::KIND_CLEAR: begin
					n_unique = 0;
					n_vertex = 0;
				end
				default: ;
			endcase
			pending_welds = {pending_welds, r};
		endfunction

		// Compare one returned result with the oldest expectation.
		function void check_result(vwd_pkg::result_t got);
			vwd_pkg::result_t want;
			results_seen++;
			if (pending_welds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing pending: index %0d new %0d status %0d",
						results_seen, got.welded_index, got.is_new, got.status);
				return;
			end
			want = pending_welds.pop_front();
			if (got.welded_index !== want.welded_index || got.is_new !== want.is_new ||
					got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: expected index %0d new %0d status %0d, %s %0d %0d %0d",
						results_seen, want.welded_index, want.is_new, want.status,
						"got index/new/status", got.welded_index, got.is_new, got.status);
			end
		endfunction
	endclass

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          item_valid   = 1'b0;
	logic                          item_stall;
	vwd_pkg::item_t                item         = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	vwd_pkg::result_t              result;
	logic                          cfg_valid    = 1'b0;
	logic                          cfg_ready;
	logic [vwd_pkg::TOL_W-1:0]     cfg_data     = '0;

	weld_tracker weld = new;
	bit          gaps_on  = 1'b1;
	bit          stall_on = 1'b1;
	bit          hold_req = 1'b0;
	int          cycles   = 0;
	longint      cx[4];
	longint      cy[4];
	longint      cz[4];

	vertex_weld_dedup u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check every result the block hands over.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			weld.check_result(result);
	end

	// Stall results at random; hold off for a long stretch on demand.
	always begin : result_backpressure
		int unsigned r;
		int          run;
		logic        level;
		@(posedge clk);
		r = $urandom_range(0, 99);
		if (hold_req) begin
			hold_req = 1'b0;
			level = 1'b1;
			run = LONG_HOLD;
		end else if (!stall_on || r < 65) begin
			level = 1'b0;
			run = stall_on ? $urandom_range(1, 6) : 1;
		end else begin
			level = 1'b1;
			run = (r < 96) ? $urandom_range(1, 4) : $urandom_range(10, 40);
		end
		result_stall <= level;
		repeat (run - 1) @(posedge clk);
	end

	function automatic vwd_pkg::item_t make_req(logic [1:0] kind, longint x, longint y,
			longint z, int idx);
		vwd_pkg::item_t req;
		req.kind = kind;
		req.pos_x = vwd_pkg::COORD_BITS'(x);
		req.pos_y = vwd_pkg::COORD_BITS'(y);
		req.pos_z = vwd_pkg::COORD_BITS'(z);
		req.vertex_index = vwd_pkg::IDX_W'(idx);
		return req;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Land near a center, scaled by the current tolerance.
	function automatic longint near_coord(longint c);
		longint spread;
		case ($urandom_range(0, 3))
			0: spread = 0;
			1: spread = weld.tol / 2;
			2: spread = weld.tol;
			default: spread = 2 * weld.tol;
		endcase
		return c + longint'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic vwd_pkg::item_t random_req();
		vwd_pkg::item_t req;
		logic [95:0]    bits;
		int unsigned    pick;
		int unsigned    k;
		int unsigned    top;
		bits = {$urandom, $urandom, $urandom};
		req = bits[$bits(vwd_pkg::item_t)-1:0];
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, 3);
		if (pick < 62) begin
			req.kind = vwd_pkg::KIND_VERTEX;
			// keep the fully random position for a share of vertices
			if (pick >= 14) begin
				req.pos_x = vwd_pkg::COORD_BITS'(near_coord(cx[k]));
				req.pos_y = vwd_pkg::COORD_BITS'(near_coord(cy[k]));
				req.pos_z = vwd_pkg::COORD_BITS'(near_coord(cz[k]));
			end
		end else if (pick < 87) begin
			req.kind = vwd_pkg::KIND_REMAP;
			top = (weld.n_vertex > vwd_pkg::MAX_VERTICES - 1)
				? vwd_pkg::MAX_VERTICES - 1 : weld.n_vertex;
			if (pick < 81)
				req.vertex_index = vwd_pkg::IDX_W'($urandom_range(0, top));
		end else if (pick < 93) begin
			req.kind = vwd_pkg::KIND_CLEAR;
		end else begin
			req.kind = KIND_UNUSED;
		end
		return req;
	endfunction

	// Offer one request, hold it until taken, then maybe idle.
	task automatic send_item(input vwd_pkg::item_t req);
		int gap;
		item <= req;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		weld.note_request(req);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every pending result.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (weld.pending_welds.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [vwd_pkg::TOL_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		weld.set_tolerance(v);
	endtask

	initial begin
		logic [vwd_pkg::TOL_W-1:0] tol_v;
		longint                    bx, by, bz;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero tolerance after reset: nothing welds, unseen indexes, unused kind
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 4095));
		send_item(make_req(KIND_UNUSED, -1, -1, -1, 4095));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MIN, COORD_MIN, COORD_MIN, 4095));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 2));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 3));
		send_item(make_req(vwd_pkg::KIND_CLEAR, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 0));

		// widest tolerance: just inside and exactly at the weld distance
		write_tolerance(vwd_pkg::TOL_W'(TOL_MAX));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MIN, COORD_MIN, COORD_MIN, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MAX, COORD_MAX, COORD_MAX, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MIN + TOL_MAX - 1, COORD_MIN,
			COORD_MIN, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, COORD_MIN + TOL_MAX, COORD_MIN,
			COORD_MIN, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 0, 0, 0, 0));

		// one big cluster, a few strays
		send_item(make_req(vwd_pkg::KIND_CLEAR, 0, 0, 0, 0));
		bx = $signed(20'($urandom));
		by = $signed(20'($urandom));
		bz = $signed(20'($urandom));
		for (int n = 0; n < 20; n++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(make_req(vwd_pkg::KIND_VERTEX, $urandom, $urandom, $urandom,
					$urandom));
			else
				send_item(make_req(vwd_pkg::KIND_VERTEX,
					bx + $urandom_range(0, 1 << 21) - (1 << 20),
					by + $urandom_range(0, 1 << 21) - (1 << 20),
					bz + $urandom_range(0, 1 << 21) - (1 << 20), $urandom));
		end
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 4095));
		repeat (3) send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, $urandom_range(0, 24)));
		send_item(make_req(vwd_pkg::KIND_CLEAR, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 0));

		// small tolerance: exact boundary on a diagonal and first-match order
		write_tolerance(vwd_pkg::TOL_W'(5));
		send_item(make_req(vwd_pkg::KIND_CLEAR, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 0, 0, 0, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 3, 4, 0, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 1, 2, 2, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 3, 4, 1, 0));
		send_item(make_req(vwd_pkg::KIND_VERTEX, 2, 2, 0, 0));
		send_item(make_req(vwd_pkg::KIND_REMAP, 0, 0, 0, 3));

		// random phases, each with its own tolerance and clusters
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: tol_v = vwd_pkg::TOL_W'(4096);
				1: tol_v = vwd_pkg::TOL_W'($urandom_range(1, TOL_MAX));
				2: tol_v = vwd_pkg::TOL_W'(2);
				default: tol_v = vwd_pkg::TOL_W'(1 << 20);
			endcase
			write_tolerance(tol_v);
			stall_on = (ph != 3);
			for (int k = 0; k < 4; k++) begin
				cx[k] = $signed(vwd_pkg::COORD_BITS'($urandom));
				cy[k] = $signed(vwd_pkg::COORD_BITS'($urandom));
				cz[k] = $signed(vwd_pkg::COORD_BITS'($urandom));
			end
			cx[0] = ph[0] ? COORD_MAX : COORD_MIN;
			for (int n = 0; n < 24; n++) begin
				// long receiver hold while requests keep coming
				if (ph == 1 && n == 8)
					hold_req = 1'b1;
				gaps_on = (ph != 3) && !(ph == 1 && n >= 8 && n < 20);
				if (ph == 2 && n == 12)
					drain();
				send_item(random_req());
			end
		end

		drain();
		if (weld.mismatches == 0 && weld.pending_welds.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
